// File: src/tbd_pkg.sv
// Shared types and constants for the four-button toggle debouncer.
// No dependencies; imported by every module of the block.
package tbd_pkg;

    localparam int TICK_W          = 8;
    localparam int NUM_BUTTONS_DEF = 4;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    localparam logic [TICK_W-1:0] PRESS_RESET   = 8'd10;
    localparam logic [TICK_W-1:0] RELEASE_RESET = 8'd200;

    typedef enum logic [0:0] {
        REG_PRESS_TICKS   = 1'b0,
        REG_RELEASE_TICKS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [TICK_W-1:0] press_ticks;
        logic [TICK_W-1:0] release_ticks;
    } t_cfg;

    typedef struct packed {
        logic level;
        logic relay;
        logic toggle;
        logic busy;
    } t_btn_status;

endpackage

// File: src/four_button_toggle_debouncer.sv
// Top level of the toggle debouncer: input beat register, button lanes, result register.
// Depends on tbd_pkg, tbd_apb_regs and tbd_button.
//
// Each input beat is one timer tick with the active-low pin levels. The block takes one
// beat per clock while o_in_stall is low and returns one result beat per tick: a beat is
// captured in the input register, then the per-button compare/decrement/reload logic
// writes the result register. The input side stays open while a result waits as long as
// the input register is free. Settle times are written over APB and apply at each
// counter's next reload; no clearing pass follows reset.
module four_button_toggle_debouncer #(
    parameter int NUM_BUTTONS = tbd_pkg::NUM_BUTTONS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [NUM_BUTTONS-1:0]         i_raw_pins,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [NUM_BUTTONS-1:0]         o_relay_states,
    output logic [NUM_BUTTONS-1:0]         o_toggled_mask,
    output logic [NUM_BUTTONS-1:0]         o_debounced_levels,
    output logic                           o_timer_idle,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tbd_pkg::*;

    t_cfg                   w_cfg;
    t_btn_status            w_status [NUM_BUTTONS];
    logic                   r_in_valid;
    logic [NUM_BUTTONS-1:0] r_pins;
    logic                   r_out_valid;
    logic [NUM_BUTTONS-1:0] r_relay;
    logic [NUM_BUTTONS-1:0] r_toggle;
    logic [NUM_BUTTONS-1:0] r_level;
    logic                   r_all_rel;
    logic [NUM_BUTTONS-1:0] n_relay;
    logic [NUM_BUTTONS-1:0] n_toggle;
    logic [NUM_BUTTONS-1:0] n_level;
    logic [NUM_BUTTONS-1:0] w_busy;
    logic                   w_advance;
    logic                   w_fire;

    tbd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_pins <= i_raw_pins;
        end
    end

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
        tbd_button u_btn (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_fire),
            .i_pressed (~r_pins[b]),
            .i_cfg     (w_cfg),
            .o_status  (w_status[b])
        );
    end

    always_comb begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            n_relay[b]  = w_status[b].relay;
            n_toggle[b] = w_status[b].toggle;
            n_level[b]  = w_status[b].level;
            w_busy[b]   = w_status[b].busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_relay   <= n_relay;
            r_toggle  <= n_toggle;
            r_level   <= n_level;
            r_all_rel <= ~|w_busy;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_relay_states     = r_relay;
    assign o_toggled_mask     = r_toggle;
    assign o_debounced_levels = r_level;
    assign o_timer_idle       = r_all_rel;

    a_toggle_is_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_toggled_mask & ~o_debounced_levels) == '0))
        else $error("toggle reported on a button not debounced pressed");

    a_held_press_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_debounced_levels & ~o_toggled_mask) != '0) |-> !o_timer_idle)
        else $error("timer_idle set while a button is held pressed");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !o_in_stall |=> o_out_valid)
        else $error("processed beat produced no result");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && r_in_valid)
        else $error("input stalled with a free pipeline");

endmodule

// File: src/tbd_apb_regs.sv
// APB register file holding the press and release settle times.
// Depends on tbd_pkg.
module tbd_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output tbd_pkg::t_cfg                  o_cfg
);
    import tbd_pkg::*;

    logic [TICK_W-1:0] r_press_ticks;
    logic [TICK_W-1:0] r_release_ticks;
    logic [TICK_W-1:0] w_rd_val;
    logic              w_wr;
    t_reg_idx          w_idx;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_ticks   <= PRESS_RESET;
            r_release_ticks <= RELEASE_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PRESS_TICKS:   r_press_ticks   <= pwdata[TICK_W-1:0];
                REG_RELEASE_TICKS: r_release_ticks <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PRESS_TICKS:   w_rd_val = r_press_ticks;
            REG_RELEASE_TICKS: w_rd_val = r_release_ticks;
            default:           w_rd_val = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-TICK_W){1'b0}}, w_rd_val};

    assign o_cfg.press_ticks   = r_press_ticks;
    assign o_cfg.release_ticks = r_release_ticks;

endmodule

// File: src/tbd_button.sv
// One button: settle counter, debounced level and relay bit.
// Depends on tbd_pkg; status reflects the state after the current beat.
module tbd_button (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_pressed,
    input  tbd_pkg::t_cfg        i_cfg,
    output tbd_pkg::t_btn_status o_status
);
    import tbd_pkg::*;

    logic [TICK_W-1:0] r_cnt;
    logic [TICK_W-1:0] n_cnt;
    logic              r_level;
    logic              n_level;
    logic              r_relay;
    logic              n_relay;
    logic [TICK_W-1:0] w_dec;
    logic              w_toggle;
    logic              w_busy;

    assign w_dec = r_cnt - 1'b1;

    always_comb begin
        n_cnt    = r_cnt;
        n_level  = r_level;
        n_relay  = r_relay;
        w_toggle = 1'b0;
        w_busy   = 1'b0;
        if (i_pressed == r_level) begin
            n_cnt  = r_level ? i_cfg.release_ticks : i_cfg.press_ticks;
            w_busy = r_level;
        end else if (w_dec == '0) begin
            n_level = i_pressed;
            if (i_pressed) begin
                n_relay  = ~r_relay;
                w_toggle = 1'b1;
                n_cnt    = i_cfg.release_ticks;
            end else begin
                n_cnt  = i_cfg.press_ticks;
                w_busy = 1'b1;
            end
        end else begin
            n_cnt  = w_dec;
            w_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= PRESS_RESET;
            r_level <= 1'b0;
            r_relay <= 1'b0;
        end else if (i_en) begin
            r_cnt   <= n_cnt;
            r_level <= n_level;
            r_relay <= n_relay;
        end
    end

    assign o_status.level  = n_level;
    assign o_status.relay  = n_relay;
    assign o_status.toggle = w_toggle;
    assign o_status.busy   = w_busy;

endmodule
